@@ rtl/tfvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Tank fill valve sequencer package
// Shared types and constants: register indexes, controller states, fill
// steps and the fixed widths of the level arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfvs_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TANK_HEIGHT = 3'd0;
  localparam logic [2:0] REG_SOUND_SPEED = 3'd1;
  localparam logic [2:0] REG_LOW_LEVEL   = 3'd2;
  localparam logic [2:0] REG_HIGH_LEVEL  = 3'd3;
  localparam logic [2:0] REG_VALVE_DELAY = 3'd4;

  // Reset values of the registers.
  localparam logic [11:0] TANK_HEIGHT_RST = 12'd90;
  localparam logic [15:0] SOUND_SPEED_RST = 16'd22479;
  localparam logic [9:0]  LOW_LEVEL_RST   = 10'd333;
  localparam logic [9:0]  HIGH_LEVEL_RST  = 10'd556;
  localparam logic [15:0] VALVE_DELAY_RST = 16'd1000;

  // Echoes longer than this are treated as a sensor timeout.
  localparam logic [14:0] ECHO_TIMEOUT_US = 15'd26000;

  // Full scale of the level, in tenths of a percent.
  localparam logic [9:0] LEVEL_MAX = 10'd1000;

  // Last step indexes of the multiply (echo width less one) and of the level divide (quotient bits less one).
  localparam logic [3:0] MUL_LAST = 4'd14;
  localparam logic [3:0] DIV_LAST = 4'd10;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    STEP_WAIT  = 3'd0,
    STEP_MAIN  = 3'd1,
    STEP_TANK  = 3'd2,
    STEP_PUMP  = 3'd3,
    STEP_STOP  = 3'd4,
    STEP_CLOSE = 3'd5
  } step_t;

endpackage

`default_nettype wire

@@ rtl/tank_fill_valve_sequencer.sv @@
// ----------------------------------------------------------------------------
// Tank fill valve sequencer
// Turns ultrasonic echo times into a tank level and drives a six-step
// fill sequence for the main valve, the tank valve and the pump.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload (lowest bit first)
//   in_      slave      tuser: echo_valid; tdata: echo_us[14:0], one pad bit
//   out_     master     tdata: main_valve_open, tank_valve_open, pump_on,
//                       step_now[2:0], level_now[9:0], sensor_timeout,
//                       fill_done, six pad bits
//   cfg_     write      cfg_addr selects the register, cfg_wdata its value
//
// An item with a good echo is accepted, then passes the bit-serial multiply
// of echo time by sound speed (one echo bit a cycle), a step that forms the
// water column, the restoring divide that scales it to tenths of a percent
// (one quotient bit a cycle) and the sequencer update. An item without a
// measurement, or with a timed-out echo, goes from acceptance straight to
// the sequencer update. The result register holds one item; while it waits
// for out_tready the block finishes the next item's arithmetic and then holds.
// rst_n is synchronous and active low.
//
`timescale 1ns / 1ps
`default_nettype none

module tank_fill_valve_sequencer
  import tfvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items, one per millisecond tick.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [14:0] echo_us, [15] zero pad
  input  wire logic        in_tuser,   // [0] echo_valid
  // Result items, one per tick.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] main_valve_open, [1] tank_valve_open,
                                       // [2] pump_on, [5:3] step_now,
                                       // [15:6] level_now, [16] sensor_timeout,
                                       // [17] fill_done, [23:18] zero pad
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [11:0] height_r;
  logic [15:0] speed_r;
  logic [9:0]  low_r;
  logic [9:0]  high_r;
  logic [15:0] delay_r;

  // Controller and arithmetic registers.
  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [30:0] prod_r, prod_nxt;    // upper part accumulates, lower part holds the echo bits
  logic [11:0] rem_r, rem_nxt;
  logic [10:0] dend_r, dend_nxt;    // dividend bits shift out, quotient bits shift in
  logic        tout_r, tout_nxt;

  // Architectural state.
  logic [9:0]  level_r, level_nxt;
  step_t       step_r, step_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Controller outputs.
  logic        accept;
  logic        finish;

  // Arithmetic intermediates.
  logic [14:0] echo;
  logic        echo_bad;
  logic [16:0] mul_sum;
  logic [13:0] dist_mm;
  logic [11:0] column;
  logic [21:0] dividend;
  logic [12:0] trial;
  logic        trial_ge;
  logic [12:0] trial_diff;
  logic [10:0] quot;

  // Sequencer intermediates.
  logic [15:0] count;
  logic        due;
  logic        done_flag;

  assign echo     = in_tdata[14:0];
  assign echo_bad = (echo == 15'd0) || (echo > ECHO_TIMEOUT_US);

  // ---------------------------------------------------------------------------
  // Configuration port. Writes to indexes beyond the list are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= TANK_HEIGHT_RST;
      speed_r  <= SOUND_SPEED_RST;
      low_r    <= LOW_LEVEL_RST;
      high_r   <= HIGH_LEVEL_RST;
      delay_r  <= VALVE_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TANK_HEIGHT: height_r <= cfg_wdata[11:0];
        REG_SOUND_SPEED: speed_r  <= cfg_wdata;
        REG_LOW_LEVEL:   low_r    <= cfg_wdata[9:0];
        REG_HIGH_LEVEL:  high_r   <= cfg_wdata[9:0];
        REG_VALVE_DELAY: delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Next state of the controller.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // Only a good echo needs the arithmetic; everything else goes
          // straight to the sequencer update.
          state_nxt = (in_tuser && !echo_bad) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // A zero tank height reads as an empty tank; the divide is skipped.
        state_nxt = (height_r == 12'd0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: finish    = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Level arithmetic: shift-and-add multiply, then restoring divide.
  // ---------------------------------------------------------------------------
  always_comb begin
    // Multiply step: add the sound speed when the current echo bit is set,
    // then shift the whole accumulator right by one.
    mul_sum = {1'b0, prod_r[30:15]} + (prod_r[0] ? {1'b0, speed_r} : 17'd0);

    // Distance in mm is the product shifted down by 17; the water column is
    // the tank height less that, floored at zero.
    dist_mm = prod_r[30:17];
    column  = (dist_mm >= {2'b00, height_r}) ? 12'd0 : (height_r - dist_mm[11:0]);
    // column * 1000 as column * (1024 - 16 - 8).
    dividend = {column, 10'd0} - {6'd0, column, 4'd0} - {7'd0, column, 3'd0};

    // Divide step. The column never exceeds the height, so the quotient fits
    // in 11 bits and the upper 11 dividend bits start below the divisor.
    trial      = {rem_r, dend_r[10]};
    trial_ge   = trial >= {1'b0, height_r};
    trial_diff = trial - {1'b0, height_r};
    quot       = {dend_r[9:0], trial_ge};
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    dend_nxt  = dend_r;
    tout_nxt  = tout_r;
    level_nxt = level_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prod_nxt = {16'd0, echo};
          tout_nxt = in_tuser && echo_bad;
          cnt_nxt  = 4'd0;
        end
      end
      ST_MUL: begin
        prod_nxt = {mul_sum, prod_r[14:1]};
        cnt_nxt  = cnt_r + 4'd1;
      end
      ST_PREP: begin
        rem_nxt  = {1'b0, dividend[21:11]};
        dend_nxt = dividend[10:0];
        cnt_nxt  = 4'd0;
        if (height_r == 12'd0) begin
          level_nxt = 10'd0;
        end
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? trial_diff[11:0] : trial[11:0];
        dend_nxt = quot;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          level_nxt = (quot > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : quot[9:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Fill sequencer. It runs once per item, after the level has been updated.
  // The elapsed count saturates and is cleared by every action that starts a
  // timed wait.
  // ---------------------------------------------------------------------------
  always_comb begin
    count       = (elapsed_r == ELAPSED_MAX) ? ELAPSED_MAX : (elapsed_r + 16'd1);
    due         = count >= delay_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    done_flag   = 1'b0;
    if (finish) begin
      elapsed_nxt = count;
      case (step_r)
        STEP_WAIT: begin
          if (level_r < low_r) begin
            step_nxt    = STEP_MAIN;
            elapsed_nxt = 16'd0;
          end
        end
        STEP_MAIN: begin
          if (due) begin
            step_nxt    = STEP_TANK;
            elapsed_nxt = 16'd0;
          end
        end
        STEP_TANK: begin
          if (due) begin
            step_nxt = STEP_PUMP;
          end
        end
        STEP_PUMP: begin
          if (level_r > high_r) begin
            step_nxt    = STEP_STOP;
            elapsed_nxt = 16'd0;
          end
        end
        STEP_STOP: begin
          if (due) begin
            step_nxt    = STEP_CLOSE;
            elapsed_nxt = 16'd0;
          end
        end
        STEP_CLOSE: begin
          if (due) begin
            step_nxt  = STEP_WAIT;
            done_flag = 1'b1;
          end
        end
        default: step_nxt = STEP_WAIT;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The drives follow directly from the new step.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0,
                       done_flag,
                       tout_r,
                       level_r,
                       step_nxt,
                       (step_nxt == STEP_PUMP),
                       (step_nxt == STEP_TANK) || (step_nxt == STEP_PUMP) ||
                         (step_nxt == STEP_STOP),
                       (step_nxt != STEP_WAIT)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      tout_r      <= 1'b0;
      level_r     <= 10'd0;
      step_r      <= STEP_WAIT;
      elapsed_r   <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tout_r      <= tout_nxt;
      level_r     <= level_nxt;
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    dend_r     <= dend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/tfvs_checker.sv @@
// ----------------------------------------------------------------------------
// Tank fill valve sequencer port checker
// Watches the ports of the top level and checks the valve interlocks, the
// value ranges of a result and the one-at-a-time input handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfvs_port_checker
  import tfvs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // The pump only runs with both valves open, the tank valve only with the
  // main valve open.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[2] || out_tdata[1]) && (!out_tdata[1] || out_tdata[0]))
    else $error("valve interlock broken");

  // The level never exceeds full scale, and the end of a fill leaves step zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:6] <= LEVEL_MAX) &&
                   (!out_tdata[17] || out_tdata[5:3] == STEP_WAIT))
    else $error("level or fill end out of range");

  // Items are worked on one at a time: no second item the cycle after one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

endmodule

bind tank_fill_valve_sequencer tfvs_port_checker u_tfvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ test/tfvs_checker.sv @@
// ----------------------------------------------------------------------------
// Tank fill valve sequencer checker
// Watches the configuration port and both item channels, predicts each
// result from its own copy of the registers and sequencer state, and
// compares every result item with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfvs_checker
  import tfvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [14:0] echo_us, [15] zero pad
  input  wire logic        in_tuser,   // [0] echo_valid
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [0] main_valve_open, [1] tank_valve_open,
                                       // [2] pump_on, [5:3] step_now,
                                       // [15:6] level_now, [16] sensor_timeout,
                                       // [17] fill_done, [23:18] zero pad
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output int               outstanding,
  output int               fail_count,
  output int               checked_count,
  output int               fill_count,
  output int               timeout_count
);

  // Same bit order as out_tdata: the last member sits in bit 0.
  typedef struct packed {
    logic       fill_done;
    logic       sensor_timeout;
    logic [9:0] level;
    step_t      step;
    logic       pump;
    logic       tank_valve;
    logic       main_valve;
  } tick_result_t;

  logic [11:0] height_mm;
  logic [15:0] speed_q16;
  logic [9:0]  low_tenths;
  logic [9:0]  high_tenths;
  logic [15:0] delay_ms;

  step_t       fill_step;
  logic [9:0]  level_tenths;
  logic [15:0] elapsed_ms;

  tick_result_t pending_results[$];
  int fails = 0;
  int checked = 0;
  int fills = 0;
  int timeouts = 0;

  function automatic logic [9:0] level_of_echo(logic [14:0] echo);
    logic [31:0] dist_mm;
    logic [31:0] column;
    logic [31:0] scaled;
    if (height_mm == 12'd0) return 10'd0;
    dist_mm = ({17'd0, echo} * {16'd0, speed_q16}) >> 17;
    column = (dist_mm >= {20'd0, height_mm}) ? 32'd0 : {20'd0, height_mm} - dist_mm;
    scaled = column * 32'd1000 / {20'd0, height_mm};
    if (scaled > {22'd0, LEVEL_MAX}) scaled = {22'd0, LEVEL_MAX};
    return scaled[9:0];
  endfunction

  // Level update first, then one step of the fill sequencer.
  function automatic tick_result_t advance_tick(logic echo_valid, logic [14:0] echo);
    tick_result_t r;
    logic [15:0]  count;
    logic         due;
    r = '0;
    if (echo_valid) begin
      if (echo == 15'd0 || echo > ECHO_TIMEOUT_US) r.sensor_timeout = 1'b1;
      else level_tenths = level_of_echo(echo);
    end
    count = (elapsed_ms == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ms + 16'd1;
    due = (count >= delay_ms);
    elapsed_ms = count;
    case (fill_step)
      STEP_WAIT: if (level_tenths < low_tenths) begin
        fill_step = STEP_MAIN;
        elapsed_ms = 16'd0;
      end
      STEP_MAIN: if (due) begin
        fill_step = STEP_TANK;
        elapsed_ms = 16'd0;
      end
      STEP_TANK: if (due) fill_step = STEP_PUMP;
      STEP_PUMP: if (level_tenths > high_tenths) begin
        fill_step = STEP_STOP;
        elapsed_ms = 16'd0;
      end
      STEP_STOP: if (due) begin
        fill_step = STEP_CLOSE;
        elapsed_ms = 16'd0;
      end
      STEP_CLOSE: if (due) begin
        fill_step = STEP_WAIT;
        r.fill_done = 1'b1;
      end
      default: fill_step = STEP_WAIT;
    endcase
    r.main_valve = (fill_step >= STEP_MAIN && fill_step <= STEP_CLOSE);
    r.tank_valve = (fill_step >= STEP_TANK && fill_step <= STEP_STOP);
    r.pump       = (fill_step == STEP_PUMP);
    r.step       = fill_step;
    r.level      = level_tenths;
    return r;
  endfunction

  function automatic string describe(tick_result_t r);
    return $sformatf("main %b tank %b pump %b step %0d level %0d timeout %b done %b",
                     r.main_valve, r.tank_valve, r.pump, r.step, r.level,
                     r.sensor_timeout, r.fill_done);
  endfunction

  task automatic note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (!rst_n) begin
      height_mm    = TANK_HEIGHT_RST;
      speed_q16    = SOUND_SPEED_RST;
      low_tenths   = LOW_LEVEL_RST;
      high_tenths  = HIGH_LEVEL_RST;
      delay_ms     = VALVE_DELAY_RST;
      fill_step    = STEP_WAIT;
      level_tenths = 10'd0;
      elapsed_ms   = 16'd0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TANK_HEIGHT: height_mm   = cfg_wdata[11:0];
          REG_SOUND_SPEED: speed_q16   = cfg_wdata;
          REG_LOW_LEVEL:   low_tenths  = cfg_wdata[9:0];
          REG_HIGH_LEVEL:  high_tenths = cfg_wdata[9:0];
          REG_VALVE_DELAY: delay_ms    = cfg_wdata;
          default: ;
        endcase
      end
      // A result accepted on the same edge as an input belongs to an older item.
      if (out_tvalid && out_tready) begin
        got = tick_result_t'(out_tdata[17:0]);
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with none expected: %s", describe(got)));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_failure($sformatf("result %0d: expected %s; got %s",
                                   checked, describe(want), describe(got)));
        end
        checked++;
      end
      if (in_tvalid && in_tready) begin
        want = advance_tick(in_tuser, in_tdata[14:0]);
        pending_results.push_back(want);
        if (want.sensor_timeout) timeouts++;
        if (want.fill_done) fills++;
      end
    end
    outstanding   <= pending_results.size();
    fail_count    <= fails;
    checked_count <= checked;
    fill_count    <= fills;
    timeout_count <= timeouts;
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Tank fill valve sequencer testbench
// Drives millisecond ticks with echo times through the block under a series
// of register settings, with random idling on both channels; a separate
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tfvs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;    // [14:0] echo_us, [15] zero pad
  logic        in_tuser = 1'b0;     // [0] echo_valid
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [0] main_valve_open, [1] tank_valve_open,
                                    // [2] pump_on, [5:3] step_now,
                                    // [15:6] level_now, [16] sensor_timeout,
                                    // [17] fill_done, [23:18] zero pad
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [15:0] cfg_wdata = 16'd0;

  int outstanding;
  int fail_count;
  int checked_count;
  int fill_count;
  int timeout_count;

  // The testbench's view of the height and speed, used only to aim echoes
  // at an empty or a full tank so that the sequencer gets round its steps.
  int unsigned cur_height = 90;
  int unsigned cur_speed = 22479;
  // When calm is set neither side idles, giving stretches at full rate.
  bit calm = 1'b0;
  int ticks_sent = 0;
  int settings_count = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  tank_fill_valve_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tfvs_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .outstanding   (outstanding),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .fill_count    (fill_count),
    .timeout_count (timeout_count)
  );

  // Idle lengths: mostly none or short ones, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int unsigned one_of(int unsigned a, int unsigned b, int unsigned c);
    case ($urandom_range(0, 2))
      0: return a;
      1: return b;
      default: return c;
    endcase
  endfunction

  // An echo long enough to put the water column at or below zero, capped at
  // the longest echo that still counts as a measurement.
  function automatic int unsigned empty_echo();
    longint unsigned e;
    if (cur_speed == 0) return ECHO_TIMEOUT_US;
    e = ((longint'(cur_height) << 17) / cur_speed) + $urandom_range(1, 64);
    if (e > ECHO_TIMEOUT_US) e = ECHO_TIMEOUT_US;
    return int'(e);
  endfunction

  // The receiver stalls at random; it only ever lowers out_tready for a
  // stretch and then raises it again on a later edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Present one tick and hold it until the block takes it. in_tvalid stays
  // high into the next tick unless a gap follows.
  task automatic send_tick(logic echo_valid, logic [14:0] echo);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= echo_valid;
    in_tdata  <= {1'b0, echo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every tick gives one result, so once nothing is outstanding the block is
  // idle; an extra wait covers the result register emptying.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes all five registers. With junk set, the unused upper bits of the
  // narrow registers get random values and an unmapped index is written too.
  task automatic apply_settings(logic [15:0] height, logic [15:0] speed,
                                logic [15:0] low_lvl, logic [15:0] high_lvl,
                                logic [15:0] delay_ms, bit junk);
    logic [15:0] noise;
    noise = junk ? 16'($urandom) : 16'd0;
    wait_idle();
    write_reg(REG_TANK_HEIGHT, height | (noise & 16'hF000));
    write_reg(REG_SOUND_SPEED, speed);
    write_reg(REG_LOW_LEVEL, low_lvl | (noise & 16'hFC00));
    write_reg(REG_HIGH_LEVEL, high_lvl | (noise & 16'hFC00));
    write_reg(REG_VALVE_DELAY, delay_ms);
    if (junk) write_reg(3'(REG_VALVE_DELAY + $urandom_range(1, 3)), 16'($urandom));
    cfg_we <= 1'b0;
    cur_height = height & 16'h0FFF;
    cur_speed  = speed;
    settings_count++;
  endtask

  // One random tick. Most are aimed at an empty or a full tank depending on
  // whether the tank is being drained, so the sequencer walks its steps; the
  // rest are missing measurements, timeouts and echoes of any length.
  task automatic random_tick(bit draining);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_tick(1'b0, 15'($urandom));
    end else if (roll < 15) begin
      send_tick(1'b1, $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(26001, 32767)));
    end else if (roll < 25) begin
      send_tick(1'b1, 15'($urandom));
    end else if (roll < 35) begin
      send_tick(1'b1, 15'($urandom_range(1, empty_echo())));
    end else begin
      send_tick(1'b1, draining ? 15'(empty_echo()) : 15'($urandom_range(1, 4)));
    end
  endtask

  initial begin
    int unsigned h;
    int unsigned s;
    int unsigned lo;
    int unsigned hi;
    int unsigned d;
    int unsigned n;
    int unsigned kind;
    int unsigned phase;
    int          random_ticks;
    int          run_left;
    bit          junk;
    bit          draining;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: missing measurements, timeouts on a zero echo, just
    // past the limit and at all ones, the longest good echo, a very short
    // echo, two with alternating bit patterns and two more in between.
    send_tick(1'b0, 15'd0);
    send_tick(1'b1, 15'd0);
    send_tick(1'b1, 15'd26001);
    send_tick(1'b1, 15'h7FFF);
    send_tick(1'b1, 15'd26000);
    send_tick(1'b1, 15'd1);
    send_tick(1'b0, 15'h7FFF);
    send_tick(1'b1, 15'h2AAA);
    send_tick(1'b1, 15'h5555);
    send_tick(1'b1, 15'd300);
    send_tick(1'b1, 15'd500);

    // No delay between actions: the sequencer runs through the rest of the fill
    // sequence, ending with the pulse as the last valve closes.
    apply_settings(16'd90, 16'd22479, 16'd333, 16'd556, 16'd0, 1'b0);
    repeat (3) send_tick(1'b1, 15'd26000);
    repeat (4) send_tick(1'b1, 15'd1);

    // Zero tank height reads as empty; thresholds above full scale.
    apply_settings(16'd0, 16'd65535, 16'd1023, 16'd1023, 16'd1, 1'b0);
    send_tick(1'b1, 15'd1);
    send_tick(1'b1, 15'd26000);
    send_tick(1'b1, 15'd13000);

    // Oversized writes keep only their low bits; slowest sound, longest delay.
    apply_settings(16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd65535, 1'b1);
    send_tick(1'b1, 15'd26000);
    send_tick(1'b1, 15'd1);
    send_tick(1'b0, 15'd0);

    // Random phases. The first four force the extreme settings; after that
    // most phases use a realistic tank with short delays.
    phase = 0;
    random_ticks = 0;
    run_left = 0;
    draining = 1'b0;
    while (random_ticks < 1500) begin
      kind = (phase < 4) ? 6 + phase : $urandom_range(0, 9);
      h    = $urandom_range(1, 4000);
      s    = $urandom_range(h * 6, 65535);
      lo   = $urandom_range(0, 1000);
      hi   = $urandom_range(lo, 1000);
      d    = $urandom_range(0, 6);
      n    = $urandom_range(60, 150);
      junk = 1'b0;
      case (kind)
        6: begin
          d = $urandom_range(0, 1) ? 65535 : 0;
          if (d != 0) n = 30;
        end
        7: begin
          lo = one_of(0, 1000, 1023);
          hi = one_of(0, 1000, 1023);
        end
        8: begin
          h = one_of(1, 4095, h);
          s = one_of(0, 1, 65535);
        end
        9: junk = 1'b1;
        default: ;
      endcase
      apply_settings(16'(h), 16'(s), 16'(lo), 16'(hi), 16'(d), junk);
      calm = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        if (run_left == 0) begin
          draining = !draining;
          run_left = $urandom_range(3, 40);
        end
        run_left--;
        random_tick(draining);
        random_ticks++;
      end
      calm = 1'b0;
      phase++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings; %0d results checked.",
             ticks_sent, settings_count, checked_count);
    $display("The sequencer completed %0d fills and saw %0d sensor timeouts.",
             fill_count, timeout_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which needs only a few milliseconds.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results still expected.", outstanding);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
